>>> hdl/ata_pio_command_issue_top_defines.svh
// ----------------------------------------------------------------------------
// ATA PIO command issue: assertion macros
// Concurrent assertion wrappers shared by the command issue modules.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_COMMAND_ISSUE_TOP_DEFINES_SVH
`define ATA_PIO_COMMAND_ISSUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define APCI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apci: assertion failed");
// Next-cycle implication, checked outside reset.
`define APCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apci: assertion failed");
`else
`define APCI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define APCI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/apci_pkg.sv
// ----------------------------------------------------------------------------
// ATA PIO command issue package
// Constants, register indexes and the command descriptor shared by all parts.
// ----------------------------------------------------------------------------
package apci_pkg;

    // Command queue between the front and back parts.
    localparam int APCI_QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRIMARY_IO     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIMARY_CTRL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY_IO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY_CTRL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT_MASK   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LBA_MASK       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_MAP   = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] RST_PRIMARY_IO     = 16'h01F0;
    localparam logic [15:0] RST_PRIMARY_CTRL   = 16'h03F4;
    localparam logic [15:0] RST_SECONDARY_IO   = 16'h0170;
    localparam logic [15:0] RST_SECONDARY_CTRL = 16'h0374;
    localparam logic [3:0]  RST_PRESENT_MASK   = 4'h0;
    localparam logic [3:0]  RST_LBA_MASK       = 4'h0;
    localparam logic [7:0]  RST_POSITION_MAP   = 8'hE4;

    // Addressing limits and CHS geometry.
    localparam logic [31:0] LBA48_LIMIT = 32'h1000_0000;
    // Reciprocal of 63 scaled by 2^34; exact quotient for any 28-bit dividend.
    localparam logic [28:0] DIV63_RECIP = 29'd272696337;
    localparam int          DIV63_SHIFT = 34;

    // Device control bytes and select bases.
    localparam logic [7:0] DEVCTL_NORMAL = 8'h02;
    localparam logic [7:0] DEVCTL_HOB    = 8'h82;
    localparam logic [7:0] SELECT_CHS    = 8'hA0;
    localparam logic [7:0] SELECT_LBA    = 8'hE0;

    // Command opcodes.
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // Task file register offsets.
    localparam logic [15:0] OFS_DEVCTL   = 16'd2;
    localparam logic [15:0] OFS_SECCOUNT = 16'd2;
    localparam logic [15:0] OFS_LBA0     = 16'd3;
    localparam logic [15:0] OFS_LBA1     = 16'd4;
    localparam logic [15:0] OFS_LBA2     = 16'd5;
    localparam logic [15:0] OFS_SELECT   = 16'd6;
    localparam logic [15:0] OFS_COMMAND  = 16'd7;

    // One classified request, ready to be played out as port writes.
    typedef struct packed {
        logic        present;
        logic        lba48;
        logic [15:0] io_base;
        logic [15:0] ctl_port;
        logic [7:0]  select;
        logic [7:0]  count;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  opcode;
    } apci_desc_t;

    // Front part to queue.
    typedef struct packed {
        logic       push;
        apci_desc_t desc;
    } apci_push_t;

    // Queue head to back part.
    typedef struct packed {
        logic       avail;
        apci_desc_t desc;
    } apci_head_t;

endpackage

>>> hdl/apci_front.sv
// ----------------------------------------------------------------------------
// ATA PIO command issue: front part
// Accepts requests, picks the addressing mode and channel, computes CHS
// geometry with a reciprocal multiply, and pushes a descriptor to the queue.
// ----------------------------------------------------------------------------
module apci_front import apci_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // Request side.
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [1:0]  drive_index,
    input  logic [31:0] block_address,
    input  logic [7:0]  sector_count,
    // Configuration.
    input  logic [15:0] primary_io_base,
    input  logic [15:0] primary_ctrl_base,
    input  logic [15:0] secondary_io_base,
    input  logic [15:0] secondary_ctrl_base,
    input  logic [3:0]  drive_present_mask,
    input  logic [3:0]  drive_lba_mask,
    input  logic [7:0]  drive_position_map,
    // Queue side.
    input  logic        queue_full,
    output apci_push_t  enq
);

    // Stage A: captured request.
    logic        a_valid_reg;
    logic        a_action_reg;
    logic [1:0]  a_drive_reg;
    logic [31:0] a_lba_reg;
    logic [7:0]  a_count_reg;

    // Stage B: classified request and registered quotient.
    logic        b_valid_reg;
    logic        b_present_reg;
    logic [1:0]  b_mode_reg;
    logic        b_action_reg;
    logic        b_slave_reg;
    logic [15:0] b_io_reg;
    logic [15:0] b_ctl_reg;
    logic [31:0] b_lba_reg;
    logic [7:0]  b_count_reg;
    logic [22:0] b_quot_reg;

    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    logic        a_ready;
    logic        b_ready;
    logic        accept;
    logic        a_chan;
    logic        a_slave;
    logic [1:0]  a_mode;
    logic [56:0] a_prod;
    logic [27:0] b_rem;
    logic [7:0]  b_sect;
    logic [3:0]  b_head;
    logic [15:0] b_cyl;
    apci_desc_t  desc;

    // Pipeline handshake: each stage moves when the next one has room.
    assign b_ready = !b_valid_reg || !queue_full;
    assign a_ready = !a_valid_reg || b_ready;
    assign accept  = push && a_ready;
    assign full    = !a_ready;

    // Stage A control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= push;
        end
    end

    // Stage A payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_action_reg <= action;
            a_drive_reg  <= drive_index;
            a_lba_reg    <= block_address;
            a_count_reg  <= sector_count;
        end
    end

    // Classification: channel, position and addressing mode of the drive.
    always_comb
    begin
        a_chan  = drive_position_map[{a_drive_reg, 1'b1}];
        a_slave = drive_position_map[{a_drive_reg, 1'b0}];
        if (a_lba_reg >= LBA48_LIMIT)
        begin
            a_mode = MODE_LBA48;
        end
        else if (drive_lba_mask[a_drive_reg])
        begin
            a_mode = MODE_LBA28;
        end
        else
        begin
            a_mode = MODE_CHS;
        end
    end

    // Quotient by 63 through the scaled reciprocal; only CHS uses it.
    // A 28-bit block number divided by 63 needs 23 quotient bits.
    assign a_prod = 57'(a_lba_reg[27:0]) * 57'(DIV63_RECIP);

    // Stage B control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage B payload.
    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_present_reg <= drive_present_mask[a_drive_reg];
            b_mode_reg    <= a_mode;
            b_action_reg  <= a_action_reg;
            b_slave_reg   <= a_slave;
            b_io_reg      <= a_chan ? secondary_io_base : primary_io_base;
            b_ctl_reg     <= (a_chan ? secondary_ctrl_base : primary_ctrl_base)
                             + OFS_DEVCTL;
            b_lba_reg     <= a_lba_reg;
            b_count_reg   <= a_count_reg;
            b_quot_reg    <= a_prod[DIV63_SHIFT+22:DIV63_SHIFT];
        end
    end

    // CHS geometry: sector from the remainder, head and cylinder from the quotient.
    assign b_rem  = b_lba_reg[27:0] - ({b_quot_reg[21:0], 6'b0} - 28'(b_quot_reg));
    assign b_sect = {2'b00, b_rem[5:0]} + 8'd1;
    assign b_head = b_quot_reg[3:0];
    assign b_cyl  = b_quot_reg[19:4];

    // Descriptor assembly.
    always_comb
    begin
        desc          = '0;
        desc.present  = b_present_reg;
        desc.lba48    = (b_mode_reg == MODE_LBA48);
        desc.io_base  = b_io_reg;
        desc.ctl_port = b_ctl_reg;
        desc.count    = b_count_reg;
        case (b_mode_reg)
            MODE_LBA48:
            begin
                desc.select = SELECT_LBA | {3'b000, b_slave_reg, 4'h0};
                desc.b0     = b_lba_reg[7:0];
                desc.b1     = b_lba_reg[15:8];
                desc.b2     = b_lba_reg[23:16];
                desc.b3     = b_lba_reg[31:24];
                desc.opcode = b_action_reg ? CMD_WRITE_EXT : CMD_READ_EXT;
            end
            MODE_LBA28:
            begin
                desc.select = SELECT_LBA | {3'b000, b_slave_reg, b_lba_reg[27:24]};
                desc.b0     = b_lba_reg[7:0];
                desc.b1     = b_lba_reg[15:8];
                desc.b2     = b_lba_reg[23:16];
                desc.opcode = b_action_reg ? CMD_WRITE : CMD_READ;
            end
            default:
            begin
                desc.select = SELECT_CHS | {3'b000, b_slave_reg, b_head};
                desc.b0     = b_sect;
                desc.b1     = b_cyl[7:0];
                desc.b2     = b_cyl[15:8];
                desc.opcode = b_action_reg ? CMD_WRITE : CMD_READ;
            end
        endcase
    end

    assign enq.push = b_valid_reg && !queue_full;
    assign enq.desc = desc;

endmodule

>>> hdl/apci_queue.sv
// ----------------------------------------------------------------------------
// ATA PIO command issue: descriptor queue
// Short first-in first-out queue that decouples classification from issue.
// ----------------------------------------------------------------------------
`include "ata_pio_command_issue_top_defines.svh"

module apci_queue import apci_pkg::*; #(
    parameter int DEPTH = APCI_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  apci_push_t enq,
    output logic       queue_full,
    input  logic       deq,
    output apci_head_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    apci_desc_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign queue_full = (cnt_reg == CNT_W'(DEPTH));
    assign head.avail = (cnt_reg != '0);
    assign head.desc  = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (enq.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (enq.push && !deq)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (deq && !enq.push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (enq.push)
        begin
            mem[wr_ptr_reg] <= enq.desc;
        end
    end

    `APCI_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `APCI_ASSERT_NOW(a_no_overflow, clk, rst_n, enq.push, !queue_full)
    `APCI_ASSERT_NOW(a_no_underflow, clk, rst_n, deq, cnt_reg != '0)

endmodule

>>> hdl/apci_back.sv
// ----------------------------------------------------------------------------
// ATA PIO command issue: back part
// Plays the descriptor at the queue head out as a run of port writes, one
// per cycle, into an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
`include "ata_pio_command_issue_top_defines.svh"

module apci_back import apci_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  apci_head_t  head,
    output logic        deq,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] port_address,
    output logic [7:0]  port_data,
    output logic        result_status,
    output logic        last_of_run
);

    // Step numbers of the full LBA48 run; shorter runs skip the high-order part.
    localparam logic [4:0] PH_DEVCTL    = 5'd0;
    localparam logic [4:0] PH_SELECT    = 5'd1;
    localparam logic [4:0] PH_HOB0_ON   = 5'd2;
    localparam logic [4:0] PH_HOB0_REG  = 5'd3;
    localparam logic [4:0] PH_HOB0_OFF  = 5'd4;
    localparam logic [4:0] PH_HOB1_ON   = 5'd5;
    localparam logic [4:0] PH_HOB1_REG  = 5'd6;
    localparam logic [4:0] PH_HOB1_OFF  = 5'd7;
    localparam logic [4:0] PH_HOB2_ON   = 5'd8;
    localparam logic [4:0] PH_HOB2_REG  = 5'd9;
    localparam logic [4:0] PH_HOB2_OFF  = 5'd10;
    localparam logic [4:0] PH_HOB3_ON   = 5'd11;
    localparam logic [4:0] PH_HOB3_REG  = 5'd12;
    localparam logic [4:0] PH_HOB3_OFF  = 5'd13;
    localparam logic [4:0] PH_SECCOUNT  = 5'd14;
    localparam logic [4:0] PH_LBA0      = 5'd15;
    localparam logic [4:0] PH_LBA1      = 5'd16;
    localparam logic [4:0] PH_LBA2      = 5'd17;
    localparam logic [4:0] PH_COMMAND   = 5'd18;

    logic [4:0]  phase_reg;
    logic [4:0]  phase_next;
    logic        out_valid_reg;
    logic [15:0] out_addr_reg;
    logic [7:0]  out_data_reg;
    logic        out_status_reg;
    logic        out_last_reg;

    apci_desc_t  d;
    logic        load;
    logic        step_last;
    logic [15:0] step_addr;
    logic [7:0]  step_data;

    assign d    = head.desc;
    assign load = head.avail && (!out_valid_reg || pop);

    // Port write for the current step.
    always_comb
    begin
        step_addr = d.ctl_port;
        step_data = DEVCTL_NORMAL;
        case (phase_reg)
            PH_DEVCTL, PH_HOB0_OFF, PH_HOB1_OFF, PH_HOB2_OFF, PH_HOB3_OFF:
            begin
                step_addr = d.ctl_port;
                step_data = DEVCTL_NORMAL;
            end
            PH_HOB0_ON, PH_HOB1_ON, PH_HOB2_ON, PH_HOB3_ON:
            begin
                step_addr = d.ctl_port;
                step_data = DEVCTL_HOB;
            end
            PH_SELECT:
            begin
                step_addr = d.io_base + OFS_SELECT;
                step_data = d.select;
            end
            PH_HOB0_REG:
            begin
                step_addr = d.io_base + OFS_SECCOUNT;
                step_data = 8'h00;
            end
            PH_HOB1_REG:
            begin
                step_addr = d.io_base + OFS_LBA0;
                step_data = d.b3;
            end
            PH_HOB2_REG:
            begin
                step_addr = d.io_base + OFS_LBA1;
                step_data = 8'h00;
            end
            PH_HOB3_REG:
            begin
                step_addr = d.io_base + OFS_LBA2;
                step_data = 8'h00;
            end
            PH_SECCOUNT:
            begin
                step_addr = d.io_base + OFS_SECCOUNT;
                step_data = d.count;
            end
            PH_LBA0:
            begin
                step_addr = d.io_base + OFS_LBA0;
                step_data = d.b0;
            end
            PH_LBA1:
            begin
                step_addr = d.io_base + OFS_LBA1;
                step_data = d.b1;
            end
            PH_LBA2:
            begin
                step_addr = d.io_base + OFS_LBA2;
                step_data = d.b2;
            end
            PH_COMMAND:
            begin
                step_addr = d.io_base + OFS_COMMAND;
                step_data = d.opcode;
            end
            default:
            begin
                step_addr = '0;
                step_data = '0;
            end
        endcase
    end

    // Sequencing: an absent drive ends after one step, short modes skip LBA48 steps.
    always_comb
    begin
        step_last = !d.present || (phase_reg == PH_COMMAND);
        if (step_last)
        begin
            phase_next = PH_DEVCTL;
        end
        else if (phase_reg == PH_SELECT && !d.lba48)
        begin
            phase_next = PH_SECCOUNT;
        end
        else
        begin
            phase_next = phase_reg + 5'd1;
        end
    end

    assign deq = load && step_last;

    // Step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DEVCTL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_addr_reg   <= d.present ? step_addr : 16'h0000;
            out_data_reg   <= d.present ? step_data : 8'h00;
            out_status_reg <= !d.present;
            out_last_reg   <= step_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign port_address  = out_addr_reg;
    assign port_data     = out_data_reg;
    assign result_status = out_status_reg;
    assign last_of_run   = out_last_reg;

    `APCI_ASSERT_NOW(a_error_shape, clk, rst_n, out_valid_reg && out_status_reg, out_last_reg && out_addr_reg == 16'h0000 && out_data_reg == 8'h00)
    `APCI_ASSERT_NOW(a_run_holds_head, clk, rst_n, phase_reg != PH_DEVCTL, head.avail)
    `APCI_ASSERT_NEXT(a_run_restarts, clk, rst_n, deq, phase_reg == PH_DEVCTL)

endmodule

>>> hdl/ata_pio_command_issue_top.sv
// ----------------------------------------------------------------------------
// ATA PIO command issue: top level
// Turns sector read and write requests into ordered task-file port writes.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter through a queue-style port: an item is taken at a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on the result ports while empty is low and is taken at an
// edge with pop high. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) and must only be written while no request is in flight.
// A taken request passes stage A, stage B and the queue before its first
// result reaches the output register. The back part then issues one port
// write per cycle while the receiver keeps up: 19 writes in LBA48 mode, 7
// in LBA28 or CHS mode, 1 for an absent drive; that sequencer sets the rate.
// The front part classifies a new request every cycle while not stalled; a
// queue of QUEUE_DEPTH descriptors lets it keep taking requests during a run.
// If the receiver stalls, the output register holds the current result and
// the queue and front stages fill before full rises. Reset empties all
// stages and restores the default channel bases and drive maps.
// ----------------------------------------------------------------------------
module ata_pio_command_issue_top import apci_pkg::*; #(
    parameter int QUEUE_DEPTH = APCI_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Request channel.
    input  logic                   push,
    output logic                   full,
    input  logic                   action,
    input  logic [1:0]             drive_index,
    input  logic [31:0]            block_address,
    input  logic [7:0]             sector_count,
    // Result channel.
    output logic                   empty,
    input  logic                   pop,
    output logic [15:0]            port_address,
    output logic [7:0]             port_data,
    output logic                   result_status,
    output logic                   last_of_run
);

    logic [15:0] primary_io_base_reg;
    logic [15:0] primary_ctrl_base_reg;
    logic [15:0] secondary_io_base_reg;
    logic [15:0] secondary_ctrl_base_reg;
    logic [3:0]  drive_present_mask_reg;
    logic [3:0]  drive_lba_mask_reg;
    logic [7:0]  drive_position_map_reg;

    apci_push_t  enq;
    apci_head_t  head;
    logic        queue_full;
    logic        deq;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_io_base_reg     <= RST_PRIMARY_IO;
            primary_ctrl_base_reg   <= RST_PRIMARY_CTRL;
            secondary_io_base_reg   <= RST_SECONDARY_IO;
            secondary_ctrl_base_reg <= RST_SECONDARY_CTRL;
            drive_present_mask_reg  <= RST_PRESENT_MASK;
            drive_lba_mask_reg      <= RST_LBA_MASK;
            drive_position_map_reg  <= RST_POSITION_MAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRIMARY_IO:     primary_io_base_reg     <= cfg_data;
                CFG_PRIMARY_CTRL:   primary_ctrl_base_reg   <= cfg_data;
                CFG_SECONDARY_IO:   secondary_io_base_reg   <= cfg_data;
                CFG_SECONDARY_CTRL: secondary_ctrl_base_reg <= cfg_data;
                CFG_PRESENT_MASK:   drive_present_mask_reg  <= cfg_data[3:0];
                CFG_LBA_MASK:       drive_lba_mask_reg      <= cfg_data[3:0];
                CFG_POSITION_MAP:   drive_position_map_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front part: accept and classify.
    apci_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .action              (action),
        .drive_index         (drive_index),
        .block_address       (block_address),
        .sector_count        (sector_count),
        .primary_io_base     (primary_io_base_reg),
        .primary_ctrl_base   (primary_ctrl_base_reg),
        .secondary_io_base   (secondary_io_base_reg),
        .secondary_ctrl_base (secondary_ctrl_base_reg),
        .drive_present_mask  (drive_present_mask_reg),
        .drive_lba_mask      (drive_lba_mask_reg),
        .drive_position_map  (drive_position_map_reg),
        .queue_full          (queue_full),
        .enq                 (enq)
    );

    // Descriptor queue.
    apci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (enq),
        .queue_full (queue_full),
        .deq        (deq),
        .head       (head)
    );

    // Back part: issue the port writes.
    apci_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .deq           (deq),
        .empty         (empty),
        .pop           (pop),
        .port_address  (port_address),
        .port_data     (port_data),
        .result_status (result_status),
        .last_of_run   (last_of_run)
    );

endmodule
